// ===== design/fmg_pkg.sv =====
`timescale 1ns / 1ps
package fmg_pkg;

   localparam int CHANNELS    = 4;
   localparam int TAPS        = 8;
   localparam int MAX_SAMPLES = 65536;
   localparam int SLOTS       = CHANNELS * TAPS;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RES_W       = $clog2(SLOTS + 1) + 1;
   localparam int COUNT_W     = 17;
   localparam int SUM_W       = 64;
   localparam int MUL_W       = 25;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int VALUE_W     = 48;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_FINISH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      TAG_CONV = 2'd0,
      TAG_SQ   = 2'd1,
      TAG_GRAD = 2'd2,
      TAG_IDLE = 2'd3
   } tag_kind_type;

   // Travels beside each multiply so the accumulate stage knows its target.
   typedef struct packed {
      logic               valid;
      tag_kind_type       kind;
      logic [SLOT_W-1:0]  idx;
   } mul_tag_type;

   typedef enum logic [0:0] {
      KIND_ERROR = 1'b0,
      KIND_GRAD  = 1'b1
   } rsp_kind_type;

endpackage

// ===== design/fir_mse_gradient_engine.sv =====
`timescale 1ns / 1ps
// Channel   Ports             tdata / tuser contents
// request   req_t*            tdata: weight_index, weight_value, sample_0..3,
//                             target_value; tuser: op
// response  rsp_t*            tdata: coeff_index, value, empty_batch;
//                             tuser: kind; tlast: last
//
// A load or an ignored request leaves the block idle. A sample keeps the block
// busy. One shared 25x25 multiplier does the 32 convolution products, then the
// squared error and the 32 gradient products, one per cycle. Each pass ends
// with a drain of the multiplier, and the rounded error is formed between the
// passes. A finish makes each result with the 64-step bit-serial divider and
// waits for each response to be taken. With an empty batch the divider is
// skipped and the value is zero. Reset is synchronous and clears history, sums
// and count; weights are not cleared. The block accepts no request while a
// sample or a finish run is being worked.
module fir_mse_gradient_engine (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [4:0] weight_index, [20:5] weight_value, [36:21] sample_0,
   // [52:37] sample_1, [68:53] sample_2, [84:69] sample_3,
   // [100:85] target_value, [103:101] zero
   input  logic [103:0] req_tdata,
   // [1:0] op
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [4:0] coeff_index, [52:5] value, [53] empty_batch, [55:54] zero
   output logic [55:0]  rsp_tdata,
   // [0] kind
   output logic         rsp_tuser,
   output logic         rsp_tlast
);
   import fmg_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_CONV  = 10'b0000000010,
      ST_CWAIT = 10'b0000000100,
      ST_ERR   = 10'b0000001000,
      ST_SQ    = 10'b0000010000,
      ST_GRAD  = 10'b0000100000,
      ST_GWAIT = 10'b0001000000,
      ST_FSEL  = 10'b0010000000,
      ST_DIV   = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   state_type                state_ff;
   logic [SLOT_W-1:0]        idx_ff;
   logic [RES_W-1:0]         res_ff;
   logic [15:0]              wmem [SLOTS];
   logic signed [15:0]       w_rd_ff;
   logic signed [15:0]       h_rd_ff;
   logic signed [15:0]       hist_ff [SLOTS];
   logic signed [SUM_W-1:0]  gsum_ff [SLOTS];
   logic [SLOTS-1:0]         gvalid_ff;
   logic signed [SUM_W-1:0]  esum_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic signed [39:0]       y_ff;
   logic signed [15:0]       target_ff;
   logic signed [MUL_W-1:0]  e15_ff;
   mul_tag_type              iss_ff;
   mul_tag_type              prod_tag;
   logic signed [PROD_W-1:0] prod;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [40:0]       e_full;
   logic                     sign_ff;
   logic                     rsp_v_ff;
   logic [55:0]              rsp_data_ff;
   logic                     rsp_kind_ff;
   logic                     rsp_last_ff;
   logic signed [SUM_W-1:0]  sum_sel;
   logic [SUM_W-1:0]         sum_mag;
   logic [SLOT_W-1:0]        res_slot;
   logic                     div_start, div_done;
   logic [SUM_W-1:0]         div_quo;
   logic [VALUE_W-1:0]       sat_val;
   logic                     req_acc, rsp_acc;
   op_type                   req_op;
   logic [SLOT_W:0]          req_widx;

   assign req_acc  = req_tvalid && req_tready;
   assign rsp_acc  = rsp_v_ff && rsp_tready;
   assign req_op   = op_type'(req_tuser);
   assign req_widx = {1'b0, req_tdata[4:0]};

   // Operand selection for the shared multiplier.
   always_comb begin
      case (iss_ff.kind)
         TAG_CONV: begin
            mul_a = MUL_W'(w_rd_ff);
            mul_b = MUL_W'(h_rd_ff);
         end
         TAG_SQ: begin
            mul_a = e15_ff;
            mul_b = e15_ff;
         end
         TAG_GRAD: begin
            mul_a = e15_ff <<< 1;
            mul_b = MUL_W'(h_rd_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   fmg_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .tag_in   (iss_ff),
      .a_in     (mul_a),
      .b_in     (mul_b),
      .tag_out  (prod_tag),
      .prod_out (prod)
   );

   // Rounded error: add a half, then floor shift to Q.15.
   assign e_full = 41'(y_ff) - (41'(target_ff) <<< 15) + 41'sd16384;

   assign res_slot  = SLOT_W'(res_ff - 1'b1);
   assign sum_sel   = (res_ff == '0) ? esum_ff
                    : (gvalid_ff[res_slot] ? gsum_ff[res_slot] : '0);
   assign sum_mag   = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
   assign div_start = (state_ff == ST_FSEL) && (count_ff != '0);

   fmg_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Truncated quotient with the sign restored, saturated to 48 bits.
   always_comb begin
      if (sign_ff) begin
         sat_val = (div_quo > SUM_W'(VAL_MIN)) ? VAL_MIN : VALUE_W'(-div_quo);
      end else begin
         sat_val = (div_quo > SUM_W'(VAL_MAX)) ? VAL_MAX : VALUE_W'(div_quo);
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_op == OP_LOAD && req_widx < (SLOT_W + 1)'(SLOTS)) begin
         wmem[req_widx[SLOT_W-1:0]] <= req_tdata[20:5];
      end
      w_rd_ff <= wmem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_ff.valid <= 1'b0;
         gvalid_ff    <= '0;
         esum_ff      <= '0;
         count_ff     <= '0;
         rsp_v_ff     <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         iss_ff.valid <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_acc && req_op == OP_SAMPLE
                   && count_ff != COUNT_W'(MAX_SAMPLES)) begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     for (int k = TAPS - 1; k > 0; k--) begin
                        hist_ff[c*TAPS + k] <= hist_ff[c*TAPS + k - 1];
                     end
                     hist_ff[c*TAPS] <= req_tdata[21 + 16*c +: 16];
                  end
                  target_ff <= req_tdata[100:85];
                  y_ff      <= '0;
                  idx_ff    <= '0;
                  state_ff  <= ST_CONV;
               end else if (req_acc && req_op == OP_FINISH) begin
                  res_ff   <= '0;
                  state_ff <= ST_FSEL;
               end
            end
            ST_CONV: begin
               iss_ff.valid <= 1'b1;
               iss_ff.kind  <= TAG_CONV;
               iss_ff.idx   <= idx_ff;
               idx_ff       <= idx_ff + 1'b1;
               if (idx_ff == SLOT_W'(SLOTS - 1)) begin
                  state_ff <= ST_CWAIT;
               end
            end
            ST_CWAIT: begin
               if (!iss_ff.valid && !prod_tag.valid) begin
                  state_ff <= ST_ERR;
               end
            end
            ST_ERR: begin
               e15_ff   <= MUL_W'(e_full >>> 15);
               state_ff <= ST_SQ;
            end
            ST_SQ: begin
               iss_ff.valid <= 1'b1;
               iss_ff.kind  <= TAG_SQ;
               iss_ff.idx   <= '0;
               idx_ff       <= '0;
               state_ff     <= ST_GRAD;
            end
            ST_GRAD: begin
               iss_ff.valid <= 1'b1;
               iss_ff.kind  <= TAG_GRAD;
               iss_ff.idx   <= idx_ff;
               idx_ff       <= idx_ff + 1'b1;
               if (idx_ff == SLOT_W'(SLOTS - 1)) begin
                  state_ff <= ST_GWAIT;
               end
            end
            ST_GWAIT: begin
               if (!iss_ff.valid && !prod_tag.valid) begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_FSEL: begin
               rsp_kind_ff <= (res_ff == '0) ? KIND_ERROR : KIND_GRAD;
               rsp_last_ff <= (res_ff == RES_W'(SLOTS));
               rsp_data_ff[4:0]   <= (res_ff == '0) ? 5'd0 : 5'(res_slot);
               rsp_data_ff[53]    <= (count_ff == '0);
               rsp_data_ff[55:54] <= '0;
               sign_ff <= sum_sel[SUM_W-1];
               if (count_ff == '0) begin
                  rsp_data_ff[52:5] <= '0;
                  rsp_v_ff          <= 1'b1;
                  state_ff          <= ST_OUT;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  rsp_data_ff[52:5] <= sat_val;
                  rsp_v_ff          <= 1'b1;
                  state_ff          <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_acc) begin
                  rsp_v_ff <= 1'b0;
                  if (res_ff == RES_W'(SLOTS)) begin
                     // End of the run: start a fresh batch.
                     gvalid_ff <= '0;
                     esum_ff   <= '0;
                     count_ff  <= '0;
                     for (int i = 0; i < SLOTS; i++) begin
                        hist_ff[i] <= '0;
                     end
                     state_ff <= ST_IDLE;
                  end else begin
                     res_ff   <= res_ff + 1'b1;
                     state_ff <= ST_FSEL;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // Accumulate stage behind the multiplier.
         if (prod_tag.valid) begin
            case (prod_tag.kind)
               TAG_CONV: y_ff    <= y_ff + 40'(prod);
               TAG_SQ:   esum_ff <= esum_ff + SUM_W'(prod);
               TAG_GRAD: begin
                  gsum_ff[prod_tag.idx] <= (gvalid_ff[prod_tag.idx]
                                            ? gsum_ff[prod_tag.idx] : '0)
                                           + SUM_W'(prod);
                  gvalid_ff[prod_tag.idx] <= 1'b1;
               end
               default: ;
            endcase
         end
      end
      h_rd_ff <= hist_ff[idx_ff];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request taken while a response is pending");
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[4:0] == 5'(SLOTS - 1)))
      else $error("last response is not the final slot");
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside its wait state");
   a_mul_busy: assert property (@(posedge clock) disable iff (reset)
      prod_tag.valid |-> !req_tready || $past(state_ff == ST_GWAIT))
      else $error("multiplier active while idle");
`endif
endmodule

// ===== design/fmg_mul.sv =====
`timescale 1ns / 1ps
module fmg_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  fmg_pkg::mul_tag_type              tag_in,
   input  logic signed [fmg_pkg::MUL_W-1:0]  a_in,
   input  logic signed [fmg_pkg::MUL_W-1:0]  b_in,
   output fmg_pkg::mul_tag_type              tag_out,
   output logic signed [fmg_pkg::PROD_W-1:0] prod_out
);
   import fmg_pkg::*;

   mul_tag_type              tag_ff;
   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff.valid <= tag_in.valid;
      end
      tag_ff.kind <= tag_in.kind;
      tag_ff.idx  <= tag_in.idx;
      prod_ff     <= a_in * b_in;
   end

   assign tag_out  = tag_ff;
   assign prod_out = prod_ff;
endmodule

// ===== design/fmg_divider.sv =====
`timescale 1ns / 1ps
module fmg_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [fmg_pkg::SUM_W-1:0]          dividend,
   input  logic [fmg_pkg::COUNT_W-1:0]        divisor,
   output logic                               done,
   output logic [fmg_pkg::SUM_W-1:0]          quotient
);
   import fmg_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] div_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               busy_ff, done_ff;
   logic [COUNT_W:0]   rem_sh;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      rem_sh = {rem_ff, quo_ff[SUM_W-1]};
      quo_in = {quo_ff[SUM_W-2:0], 1'b0};
      rem_in = rem_sh[COUNT_W-1:0];
      if (rem_sh >= {1'b0, div_ff}) begin
         rem_in    = COUNT_W'(rem_sh - {1'b0, div_ff});
         quo_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(SUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
         step_ff <= '0;
      end else if (busy_ff) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
